FILE: rtl/core/bsrs_pkg.sv
// Package for the bitset range and successor engine.
// Holds the command codes, the query and token structs and the default sizes.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package bsrs_pkg;

  // Default set geometry.
  localparam int SET_BITS_DEF  = 1024;
  localparam int WORD_BITS_DEF = 64;

  // Fixed field widths of the ports.
  localparam int CMD_W  = 4;
  localparam int IDX_W  = 10;
  localparam int POS_W  = 12;
  localparam int RUNS_W = 10;

  // Token fields are sized for the largest set the block supports.
  localparam int TOK_IDX_W = 16;
  localparam int TOK_RUN_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_TEST      = 4'd0,
    CMD_SET       = 4'd1,
    CMD_CLEAR     = 4'd2,
    CMD_SET_RANGE = 4'd3,
    CMD_CLR_RANGE = 4'd4,
    CMD_PREV      = 4'd5,
    CMD_NEXT      = 4'd6,
    CMD_RUNS      = 4'd7,
    CMD_EMPTY     = 4'd8
  } cmd_t;

  // Query broadcast to every cell while an item is in flight.
  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } qry_t;

  // Token that walks the chain from the lowest word to the highest.
  typedef struct packed {
    logic                 vld;
    logic                 flag;
    logic                 found;
    logic [TOK_IDX_W-1:0] idx;
    logic                 carry;
    logic [TOK_RUN_W-1:0] runs;
    logic                 nonempty;
  } tok_t;

endpackage

FILE: rtl/core/bsrs_cell.sv
// One cell of the bitset chain: holds one word of the set and updates the token.
// Depends on bsrs_pkg for the query and token structs and the command codes.
`timescale 1ns / 1ps

module bsrs_cell #(
  parameter int SET_BITS  = bsrs_pkg::SET_BITS_DEF,
  parameter int WORD_BITS = bsrs_pkg::WORD_BITS_DEF,
  parameter int CELL_IDX  = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bsrs_pkg::qry_t qry,
  input  bsrs_pkg::tok_t tok_i,
  output bsrs_pkg::tok_t tok_o
);

  localparam int BW   = $clog2(WORD_BITS);
  localparam int AW   = $clog2(SET_BITS + WORD_BITS + 1024) + 1;
  localparam int BASE = CELL_IDX * WORD_BITS;

  localparam logic [AW-1:0]        BASE_A = AW'(BASE);
  localparam logic [AW-1:0]        TOP_A  = AW'(BASE + WORD_BITS - 1);
  localparam logic [AW-1:0]        LAST_A = AW'(SET_BITS - 1);
  localparam logic [BW-1:0]        TOPB   = BW'(WORD_BITS - 1);
  localparam logic [WORD_BITS-1:0] ONES   = '1;

  function automatic logic [BW-1:0] high_bit(input logic [WORD_BITS-1:0] w);
    logic [BW-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) r = BW'(i);
    end
    return r;
  endfunction

  function automatic logic [BW-1:0] low_bit(input logic [WORD_BITS-1:0] w);
    logic [BW-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) r = BW'(i);
    end
    return r;
  endfunction

  logic [WORD_BITS-1:0] word_r, word_nxt;
  bsrs_pkg::tok_t       tok_r, tok_nxt;

  logic [AW-1:0]        lo_a, hi_a, hc_a, xc_a, r_hi;
  logic [BW-1:0]        off_n, off_p, s_b, e_b;
  logic [WORD_BITS-1:0] prev_w, next_w, fill_m, starts;
  logic [BW:0]          pc;
  logic                 wr_en, wr_fill, single;

  always_comb begin
    lo_a = AW'(qry.lo);
    hi_a = AW'(qry.hi);
    hc_a = (hi_a > LAST_A) ? LAST_A : hi_a;
    xc_a = (lo_a > LAST_A) ? LAST_A : lo_a;

    // Search windows: prev looks at or below the clipped start, next at or above.
    off_p = BW'(xc_a - BASE_A);
    off_n = BW'(lo_a - BASE_A);
    if (xc_a < BASE_A) prev_w = '0;
    else if (xc_a <= TOP_A) prev_w = word_r & (ONES >> (TOPB - off_p));
    else prev_w = word_r;
    if (lo_a > TOP_A) next_w = '0;
    else if (lo_a >= BASE_A) next_w = word_r & (ONES << off_n);
    else next_w = word_r;

    // Range fill mask for this word.
    single = (qry.cmd == bsrs_pkg::CMD_SET) || (qry.cmd == bsrs_pkg::CMD_CLEAR);
    r_hi   = single ? lo_a : hc_a;
    s_b    = (lo_a > BASE_A) ? BW'(lo_a - BASE_A) : '0;
    e_b    = (r_hi < TOP_A) ? BW'(r_hi - BASE_A) : TOPB;
    fill_m = (ONES << s_b) & (ONES >> (TOPB - e_b));

    // A run starts at a member whose lower neighbor is not a member.
    starts = word_r & ~{word_r[WORD_BITS-2:0], tok_i.carry};
    pc = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      pc = pc + (BW + 1)'(starts[i]);
    end

    wr_en   = 1'b0;
    wr_fill = 1'b0;
    tok_nxt = tok_i;
    unique case (qry.cmd) inside
      bsrs_pkg::CMD_TEST: begin
        if (lo_a >= BASE_A && lo_a <= TOP_A && lo_a <= LAST_A) tok_nxt.flag = word_r[off_n];
      end
      bsrs_pkg::CMD_SET, bsrs_pkg::CMD_SET_RANGE: begin
        wr_en   = 1'b1;
        wr_fill = 1'b1;
      end
      bsrs_pkg::CMD_CLEAR, bsrs_pkg::CMD_CLR_RANGE: begin
        wr_en = 1'b1;
      end
      bsrs_pkg::CMD_PREV: begin
        if (prev_w != '0) begin
          tok_nxt.found = 1'b1;
          tok_nxt.idx   = bsrs_pkg::TOK_IDX_W'(BASE) + bsrs_pkg::TOK_IDX_W'(high_bit(prev_w));
        end
      end
      bsrs_pkg::CMD_NEXT: begin
        if (next_w != '0 && !tok_i.found) begin
          tok_nxt.found = 1'b1;
          tok_nxt.idx   = bsrs_pkg::TOK_IDX_W'(BASE) + bsrs_pkg::TOK_IDX_W'(low_bit(next_w));
        end
      end
      bsrs_pkg::CMD_RUNS: begin
        tok_nxt.runs  = tok_i.runs + bsrs_pkg::TOK_RUN_W'(pc);
        tok_nxt.carry = word_r[WORD_BITS-1];
      end
      bsrs_pkg::CMD_EMPTY: begin
        tok_nxt.nonempty = tok_i.nonempty | (word_r != '0);
      end
      default: begin
      end
    endcase

    // Only a non-reversed range inside the set that overlaps this word writes.
    word_nxt = word_r;
    if (wr_en && lo_a <= LAST_A && lo_a <= r_hi && lo_a <= TOP_A && r_hi >= BASE_A) begin
      word_nxt = wr_fill ? (word_r | fill_m) : (word_r & ~fill_m);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r    <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_i.vld;
      if (tok_i.vld) word_r <= word_nxt;
    end
    if (tok_i.vld) begin
      tok_r.flag     <= tok_nxt.flag;
      tok_r.found    <= tok_nxt.found;
      tok_r.idx      <= tok_nxt.idx;
      tok_r.carry    <= tok_nxt.carry;
      tok_r.runs     <= tok_nxt.runs;
      tok_r.nonempty <= tok_nxt.nonempty;
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: rtl/core/bitset_range_and_successor_engine.sv
// Top level of the bitset range and successor engine: query registers, cell chain, result skid.
// Depends on bsrs_pkg and bsrs_cell.
`timescale 1ns / 1ps

// The set is held as a row of cells, one word each, and every item is carried
// by a token that walks the row from the lowest word to the highest, one cell
// per cycle, reading, updating or writing that cell's word as it passes. One
// item is in flight at a time: the result is registered from the token that
// leaves the last cell, and the next item is taken only after that token has
// left the chain. The walk through the cells is alike for every command. A result
// that finds the output occupied waits in a skid register, so results are never
// lost; the input also stalls while that skid register is full.

module bitset_range_and_successor_engine #(
  parameter int SET_BITS  = bsrs_pkg::SET_BITS_DEF,
  parameter int WORD_BITS = bsrs_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bsrs_pkg::CMD_W-1:0]          in_command,
  input  logic [bsrs_pkg::IDX_W-1:0]          in_low_index,
  input  logic [bsrs_pkg::IDX_W-1:0]          in_high_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_flag,
  output logic signed [bsrs_pkg::POS_W-1:0]   out_position,
  output logic [bsrs_pkg::RUNS_W-1:0]         out_run_count
);

  localparam int NWORDS = (SET_BITS + WORD_BITS - 1) / WORD_BITS;

  localparam logic [bsrs_pkg::POS_W-1:0] POS_NONE_NEXT = bsrs_pkg::POS_W'(SET_BITS);
  localparam logic [bsrs_pkg::POS_W-1:0] POS_NONE_PREV = '1;

  typedef struct packed {
    logic                          flag;
    logic [bsrs_pkg::POS_W-1:0]    pos;
    logic [bsrs_pkg::RUNS_W-1:0]   runs;
  } res_t;

  bsrs_pkg::qry_t qry_r;
  bsrs_pkg::tok_t launch_r;
  bsrs_pkg::tok_t chain [0:NWORDS];
  bsrs_pkg::tok_t tail;
  logic           busy_r;
  logic           pend_vld_r;
  res_t           pend_r;
  logic           out_vld_r;
  res_t           out_r;
  res_t           res;
  logic           in_xfer;
  logic           out_free;
  logic [NWORDS:0] vld_vec;

  assign in_stall = busy_r | pend_vld_r;
  assign in_xfer  = in_valid & ~in_stall;
  assign out_free = ~out_vld_r | ~out_stall;

  assign chain[0] = launch_r;
  assign tail     = chain[NWORDS];

  for (genvar k = 0; k < NWORDS; k++) begin : g_cell
    bsrs_cell #(
      .SET_BITS  (SET_BITS),
      .WORD_BITS (WORD_BITS),
      .CELL_IDX  (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .qry   (qry_r),
      .tok_i (chain[k]),
      .tok_o (chain[k+1])
    );
  end

  for (genvar k = 0; k <= NWORDS; k++) begin : g_vld
    assign vld_vec[k] = chain[k].vld;
  end

  // Shape the tail token into the result fields for the command in flight.
  always_comb begin
    res = '0;
    unique case (qry_r.cmd)
      bsrs_pkg::CMD_TEST:  res.flag = tail.flag;
      bsrs_pkg::CMD_EMPTY: res.flag = ~tail.nonempty;
      bsrs_pkg::CMD_PREV:  res.pos  = tail.found ? tail.idx[bsrs_pkg::POS_W-1:0] : POS_NONE_PREV;
      bsrs_pkg::CMD_NEXT:  res.pos  = tail.found ? tail.idx[bsrs_pkg::POS_W-1:0] : POS_NONE_NEXT;
      bsrs_pkg::CMD_RUNS:  res.runs = tail.runs[bsrs_pkg::RUNS_W-1:0];
      default: begin
      end
    endcase
  end

  // Only the valid bit of the launch token ever changes; its other fields stay at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      launch_r   <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      launch_r.vld <= in_xfer;
      if (in_xfer) busy_r <= 1'b1;
      else if (tail.vld) busy_r <= 1'b0;

      if (out_free) begin
        if (pend_vld_r) begin
          out_vld_r  <= 1'b1;
          pend_vld_r <= 1'b0;
        end else begin
          out_vld_r <= tail.vld;
        end
      end else if (tail.vld) begin
        pend_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      qry_r.cmd <= bsrs_pkg::cmd_t'(in_command);
      qry_r.lo  <= in_low_index;
      qry_r.hi  <= in_high_index;
    end
    if (out_free) begin
      out_r <= pend_vld_r ? pend_r : res;
    end else if (tail.vld) begin
      pend_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_flag      = out_r.flag;
  assign out_position  = out_r.pos;
  assign out_run_count = out_r.runs;

  // At most one token is ever on the chain.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vld_vec))
    else $error("more than one token on the cell chain");

  // A token leaves the chain only while an item is in flight.
  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n) tail.vld |-> busy_r)
    else $error("token left the chain with no item in flight");

  // The item ends only when its token leaves the chain.
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(tail.vld))
    else $error("item ended without its token");

  // The skid register is only used behind a held output.
  a_pend_out: assert property (@(posedge clk) disable iff (!rst_n) pend_vld_r |-> out_vld_r)
    else $error("skid register full while output is empty");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for bitset_range_and_successor_engine.
// Depends on bsrs_pkg (command codes and port widths) and the engine RTL.
// Drives directed, back-pressure, sparse and random command streams.
`timescale 1ns / 1ps

module testbench;

  localparam int CMD_W  = bsrs_pkg::CMD_W;
  localparam int IDX_W  = bsrs_pkg::IDX_W;
  localparam int POS_W  = bsrs_pkg::POS_W;
  localparam int RUNS_W = bsrs_pkg::RUNS_W;

  localparam int SET_SIZE         = bsrs_pkg::SET_BITS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_W'(int'(bsrs_pkg::CMD_EMPTY) + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;
  localparam logic [IDX_W-1:0] IDX_TOP          = IDX_W'(SET_SIZE - 1);
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int SETTLE_CYCLES    = 24;
  localparam int SPARSE_ITEMS     = 150;
  localparam int MIX_PHASE_ITEMS  = 140;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_t;

  typedef struct {
    int                       serial;
    logic [CMD_W-1:0]         code;
    logic [IDX_W-1:0]         lo;
    logic [IDX_W-1:0]         hi;
    logic                     flag;
    logic signed [POS_W-1:0]  position;
    logic [RUNS_W-1:0]        run_count;
  } answer_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command;
  logic [IDX_W-1:0]         in_low_index;
  logic [IDX_W-1:0]         in_high_index;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_flag;
  logic signed [POS_W-1:0]  out_position;
  logic [RUNS_W-1:0]        out_run_count;

  // Predicted contents of the set and the answers still owed by the engine.
  logic [SET_SIZE-1:0] member_bits;
  answer_t             expected_answers[$];

  int          items_sent;
  int          results_checked;
  int          error_count;
  int          backpressure_cycles;
  int          command_seen[16];
  int          burst_left;
  int          burst_max;
  int          gap_max;
  stall_mode_t stall_mode;
  int          stall_pct;
  logic        hold_off_request;

  bitset_range_and_successor_engine uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_low_index  (in_low_index),
    .in_high_index (in_high_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_flag      (out_flag),
    .out_position  (out_position),
    .out_run_count (out_run_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Applies one command to the predicted set and returns the answer it gives.
  function automatic answer_t apply_command(logic [CMD_W-1:0] code, logic [IDX_W-1:0] lo,
                                            logic [IDX_W-1:0] hi);
    answer_t a;
    int      i;
    logic    prev_bit;
    a.serial    = 0;
    a.code      = code;
    a.lo        = lo;
    a.hi        = hi;
    a.flag      = 1'b0;
    a.position  = '0;
    a.run_count = '0;
    case (code)
      bsrs_pkg::CMD_TEST:  a.flag = member_bits[lo];
      bsrs_pkg::CMD_SET:   member_bits[lo] = 1'b1;
      bsrs_pkg::CMD_CLEAR: member_bits[lo] = 1'b0;
      bsrs_pkg::CMD_SET_RANGE, bsrs_pkg::CMD_CLR_RANGE: begin
        // A reversed range runs zero iterations and leaves the set alone.
        for (i = int'(lo); i <= int'(hi); i++)
          member_bits[i] = (code == bsrs_pkg::CMD_SET_RANGE);
      end
      bsrs_pkg::CMD_PREV: begin
        a.position = '1;
        for (i = 0; i <= int'(lo); i++)
          if (member_bits[i]) a.position = POS_W'(i);
      end
      bsrs_pkg::CMD_NEXT: begin
        a.position = POS_W'(SET_SIZE);
        for (i = SET_SIZE - 1; i >= int'(lo); i--)
          if (member_bits[i]) a.position = POS_W'(i);
      end
      bsrs_pkg::CMD_RUNS: begin
        prev_bit = 1'b0;
        for (i = 0; i < SET_SIZE; i++) begin
          if (member_bits[i] && !prev_bit) a.run_count = a.run_count + 1'b1;
          prev_bit = member_bits[i];
        end
      end
      bsrs_pkg::CMD_EMPTY: a.flag = (member_bits == '0);
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [IDX_W-1:0] clip_index(int v);
    if (v < 0) return '0;
    if (v > SET_SIZE - 1) return IDX_W'(SET_SIZE - 1);
    return v[IDX_W-1:0];
  endfunction

  // Range end: mostly short ranges, with random, top-of-set, reversed and degenerate ones mixed in.
  function automatic logic [IDX_W-1:0] pick_range_end(logic [IDX_W-1:0] lo);
    int pick;
    int e;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      e = int'(lo) + int'($urandom_range(0, 80));
    else if (pick < 70)
      e = $urandom_range(0, SET_SIZE - 1);
    else if (pick < 80)
      e = (lo == 0) ? 0 : int'($urandom_range(0, int'(lo) - 1));
    else if (pick < 90)
      e = SET_SIZE - 1;
    else
      e = int'(lo);
    return clip_index(e);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic set_pacing(input int bursts, input int gaps);
    burst_max  = bursts;
    gap_max    = gaps;
    burst_left = $urandom_range(1, bursts);
  endtask

  task automatic set_receiver(input stall_mode_t mode, input int pct);
    stall_mode = mode;
    stall_pct  = pct;
  endtask

  // Ends a burst with a random gap; noise sits on the fields while valid is low.
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk);
        in_valid      <= 1'b0;
        in_command    <= CMD_W'($urandom);
        in_low_index  <= IDX_W'($urandom);
        in_high_index <= IDX_W'($urandom);
      end
      burst_left = $urandom_range(1, burst_max);
    end
  endtask

  task automatic send_item(input logic [CMD_W-1:0] code, input logic [IDX_W-1:0] lo,
                           input logic [IDX_W-1:0] hi);
    answer_t a;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_command    <= code;
    in_low_index  <= lo;
    in_high_index <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    a        = apply_command(code, lo, hi);
    a.serial = items_sent;
    items_sent++;
    command_seen[code]++;
    expected_answers.push_back(a);
    pace_sender();
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_item();
    logic [CMD_W-1:0] code;
    logic [IDX_W-1:0] lo;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < 14)      code = bsrs_pkg::CMD_TEST;
    else if (pick < 24) code = bsrs_pkg::CMD_SET;
    else if (pick < 34) code = bsrs_pkg::CMD_CLEAR;
    else if (pick < 47) code = bsrs_pkg::CMD_SET_RANGE;
    else if (pick < 60) code = bsrs_pkg::CMD_CLR_RANGE;
    else if (pick < 72) code = bsrs_pkg::CMD_PREV;
    else if (pick < 84) code = bsrs_pkg::CMD_NEXT;
    else if (pick < 91) code = bsrs_pkg::CMD_RUNS;
    else if (pick < 96) code = bsrs_pkg::CMD_EMPTY;
    else                code = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    lo = IDX_W'($urandom);
    send_item(code, lo, pick_range_end(lo));
  endtask

  task automatic test_directed();
    set_receiver(STALL_NONE, 0);
    set_pacing(4, 3);
    send_item(bsrs_pkg::CMD_EMPTY, IDX_W'($urandom), IDX_W'($urandom));
    send_item(bsrs_pkg::CMD_RUNS, IDX_W'($urandom), IDX_W'($urandom));
    send_item(bsrs_pkg::CMD_PREV, IDX_TOP, '0);
    send_item(bsrs_pkg::CMD_NEXT, '0, IDX_TOP);
    send_item(bsrs_pkg::CMD_TEST, IDX_TOP, '0);
    // Single-bit writes must ignore the high index.
    send_item(bsrs_pkg::CMD_SET, '0, IDX_TOP);
    send_item(bsrs_pkg::CMD_SET, IDX_TOP, '0);
    send_item(bsrs_pkg::CMD_TEST, '0, IDX_TOP);
    send_item(bsrs_pkg::CMD_RUNS, '0, '0);
    send_item(bsrs_pkg::CMD_SET_RANGE, IDX_TOP, '0);
    send_item(bsrs_pkg::CMD_RUNS, '0, '0);
    send_item(bsrs_pkg::CMD_SET_RANGE, '0, IDX_TOP);
    send_item(bsrs_pkg::CMD_RUNS, '0, '0);
    send_item(bsrs_pkg::CMD_EMPTY, '0, '0);
    send_item(bsrs_pkg::CMD_CLR_RANGE, IDX_W'(1), IDX_W'(SET_SIZE - 2));
    send_item(bsrs_pkg::CMD_PREV, IDX_W'(SET_SIZE - 2), '0);
    send_item(bsrs_pkg::CMD_NEXT, IDX_W'(1), '0);
    send_item(bsrs_pkg::CMD_CLEAR, IDX_TOP, IDX_W'(5));
    send_item(bsrs_pkg::CMD_NEXT, IDX_W'(1), '0);
    send_item(CMD_UNUSED_LAST, IDX_TOP, IDX_TOP);
    send_item(CMD_UNUSED_FIRST, '0, '0);
    // A word-aligned range exercises both word boundaries at once.
    send_item(bsrs_pkg::CMD_SET_RANGE, IDX_W'(64), IDX_W'(127));
    send_item(bsrs_pkg::CMD_PREV, IDX_TOP, '0);
    send_item(bsrs_pkg::CMD_TEST, IDX_W'(63), '0);
    send_item(bsrs_pkg::CMD_NEXT, IDX_W'(128), '0);
    wait_for_results();
  endtask

  // The receiver holds off while items keep coming, so the engine fills and stalls its input.
  task automatic test_backpressure();
    set_receiver(STALL_NONE, 0);
    set_pacing(1, 0);
    hold_off_request = 1'b1;
    repeat (16) send_random_item();
    wait_for_results();
  endtask

  task automatic test_sparse_search();
    int               anchor;
    int               pick;
    logic [CMD_W-1:0] code;
    logic [IDX_W-1:0] lo;
    set_receiver(STALL_RANDOM, 30);
    set_pacing(8, 5);
    anchor = SET_SIZE / 2;
    send_item(bsrs_pkg::CMD_CLR_RANGE, '0, IDX_TOP);
    send_item(bsrs_pkg::CMD_EMPTY, IDX_W'($urandom), IDX_W'($urandom));
    repeat (SPARSE_ITEMS) begin
      pick = $urandom_range(0, 99);
      lo   = IDX_W'($urandom);
      if (pick < 30) begin
        code   = bsrs_pkg::CMD_SET;
        anchor = int'(lo);
      end else if (pick < 40) begin
        code = bsrs_pkg::CMD_CLEAR;
      end else begin
        if (pick < 60)      code = bsrs_pkg::CMD_PREV;
        else if (pick < 80) code = bsrs_pkg::CMD_NEXT;
        else if (pick < 90) code = bsrs_pkg::CMD_TEST;
        else if (pick < 95) code = bsrs_pkg::CMD_EMPTY;
        else                code = bsrs_pkg::CMD_RUNS;
        // Half of the queries land right around a recently set member.
        if ($urandom_range(0, 1) == 0) lo = clip_index(anchor + int'($urandom_range(0, 6)) - 3);
      end
      send_item(code, lo, IDX_W'($urandom));
    end
    wait_for_results();
  endtask

  task automatic test_random_mix();
    set_receiver(STALL_NONE, 0);
    set_pacing(1, 0);
    repeat (MIX_PHASE_ITEMS) send_random_item();
    set_receiver(STALL_RANDOM, 30);
    set_pacing(10, 8);
    repeat (MIX_PHASE_ITEMS) send_random_item();
    wait_for_results();
    set_receiver(STALL_BURSTY, 0);
    set_pacing(6, 20);
    repeat (MIX_PHASE_ITEMS) send_random_item();
    set_receiver(STALL_RANDOM, 70);
    set_pacing(3, 2);
    repeat (MIX_PHASE_ITEMS) send_random_item();
    wait_for_results();
  endtask

  // Receiver: owns out_stall, including the long hold-off counted here.
  initial begin : receiver
    int   hold_cnt;
    int   phase_cnt;
    logic phase_stall;
    hold_cnt    = 0;
    phase_cnt   = 0;
    phase_stall = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_cnt         = HOLD_OFF_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < stall_pct);
          STALL_BURSTY: begin
            if (phase_cnt == 0) begin
              phase_stall = ~phase_stall;
              phase_cnt   = phase_stall ? $urandom_range(1, 20) : $urandom_range(1, 12);
            end
            phase_cnt--;
            out_stall <= phase_stall;
          end
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    answer_t a;
    string   tag;
    if (rst_n) begin
      if (in_valid && in_stall) backpressure_cycles++;
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_answers.size() == 0) begin
          report_mismatch("result transfer with no item outstanding", out_position, 0);
        end else begin
          a   = expected_answers.pop_front();
          tag = $sformatf("item %0d (cmd %0d lo %0d hi %0d)", a.serial, a.code, a.lo, a.hi);
          if (out_flag !== a.flag)
            report_mismatch({tag, " flag"}, out_flag, a.flag);
          if (out_position !== a.position)
            report_mismatch({tag, " position"}, out_position, a.position);
          if (out_run_count !== a.run_count)
            report_mismatch({tag, " run_count"}, out_run_count, a.run_count);
        end
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_command          = '0;
    in_low_index        = '0;
    in_high_index       = '0;
    member_bits         = '0;
    items_sent          = 0;
    results_checked     = 0;
    error_count         = 0;
    backpressure_cycles = 0;
    hold_off_request    = 1'b0;
    stall_mode          = STALL_NONE;
    stall_pct           = 0;
    burst_max           = 1;
    gap_max             = 0;
    burst_left          = 1;
    foreach (command_seen[i]) command_seen[i] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_sparse_search();
    test_random_mix();

    $display("Run covered %0d commands and %0d result transfers; input held back %0d cycles.",
             items_sent, results_checked, backpressure_cycles);
    $display("Mix: test %0d, set %0d, clear %0d, ranges %0d/%0d, prev %0d, next %0d, runs %0d",
             command_seen[bsrs_pkg::CMD_TEST], command_seen[bsrs_pkg::CMD_SET],
             command_seen[bsrs_pkg::CMD_CLEAR], command_seen[bsrs_pkg::CMD_SET_RANGE],
             command_seen[bsrs_pkg::CMD_CLR_RANGE], command_seen[bsrs_pkg::CMD_PREV],
             command_seen[bsrs_pkg::CMD_NEXT], command_seen[bsrs_pkg::CMD_RUNS]);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
